@@ rtl/lcdnib_pkg.sv @@
// lcdnib_pkg: shared types, constants and the power-up nibble table
// for the 4-bit character display sequencer
// no dependencies
package lcdnib_pkg;

    localparam logic [15:0] SHORT_DELAY_RST = 16'd20;
    localparam logic [15:0] LONG_DELAY_RST  = 16'd2000;
    localparam int          QUEUE_DEPTH     = 2;

    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [7:0] ROW_OFFSET  = 8'h40;

    localparam logic [3:0] INIT_LAST_NIB = 4'd11;
    localparam logic [3:0] BYTE_LAST_NIB = 4'd1;

    localparam logic REG_SHORT_DELAY = 1'b0;
    localparam logic REG_LONG_DELAY  = 1'b1;

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_CMD    = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_CURSOR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_DATA    = 2'd0,
        PH_EN_HIGH = 2'd1,
        PH_EN_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       is_init;
        logic [7:0] cmd_byte;
        logic       rs;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [15:0] short_delay;
        logic [15:0] long_delay;
    } delay_cfg_t;

    // power-up nibbles after the clear write: 3,3,3,2 then 0x28 0x0c 0x01 0x06
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h8;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'hC;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'h1;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'h6;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

@@ rtl/lcdnib_front.sv @@
// lcdnib_front: accepts requests and turns each into a job for the queue
// depends on lcdnib_pkg
module lcdnib_front
    import lcdnib_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [1:0] mode,
    input  logic [7:0] value,
    input  logic       row,
    input  logic [3:0] column,
    input  q_stat_t    q_stat,
    output logic       push,
    output job_t       push_job
);

    logic job_valid_reg;
    logic job_valid_next;
    job_t job_reg;
    job_t job_next;
    logic accept;

    assign cmd_ready = !job_valid_reg || !q_stat.full;
    assign accept    = cmd_valid && cmd_ready;
    assign push      = job_valid_reg && !q_stat.full;
    assign push_job  = job_reg;

    always_comb
    begin
        job_next.is_init  = 1'b0;
        job_next.cmd_byte = value;
        job_next.rs       = 1'b0;
        case (mode_t'(mode))
            MODE_INIT:
            begin
                job_next.is_init  = 1'b1;
                job_next.cmd_byte = 8'h00;
            end
            MODE_CMD:
            begin
                job_next.cmd_byte = value;
            end
            MODE_DATA:
            begin
                job_next.rs = 1'b1;
            end
            MODE_CURSOR:
            begin
                job_next.cmd_byte = CURSOR_BASE + (row ? ROW_OFFSET : 8'h00)
                                    + {4'h0, column};
            end
            default:
            begin
                job_next.is_init = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (accept)
        begin
            job_valid_next = 1'b1;
        end
        else if (push)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

@@ rtl/lcdnib_fifo.sv @@
// lcdnib_fifo: short job queue between the request side and the sequencer
// depends on lcdnib_pkg
module lcdnib_fifo
    import lcdnib_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    pop_job,
    output q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_q [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_job      = mem_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_q[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/lcdnib_back.sv @@
// lcdnib_back: nibble sequencer, expands each job into port writes
// and holds the current write in an output register; depends on lcdnib_pkg
module lcdnib_back
    import lcdnib_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  delay_cfg_t  delay_cfg,
    input  q_stat_t     q_stat,
    input  job_t        pop_job,
    output logic        pop,
    output logic        wr_valid,
    input  logic        wr_ready,
    output logic [3:0]  port_data,
    output logic        enable,
    output logic        register_select,
    output logic [15:0] hold_ticks,
    output logic        last
);

    logic        active_reg;
    logic        active_next;
    logic        is_init_reg;
    logic        is_init_next;
    logic        clear_pending_reg;
    logic        clear_pending_next;
    logic [7:0]  cmd_byte_reg;
    logic [7:0]  cmd_byte_next;
    logic        rs_reg;
    logic        rs_next;
    logic [3:0]  nib_idx_reg;
    logic [3:0]  nib_idx_next;
    phase_t      phase_reg;
    phase_t      phase_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [3:0]  port_data_reg;
    logic [3:0]  port_data_next;
    logic        enable_reg;
    logic        enable_next;
    logic        rs_out_reg;
    logic        rs_out_next;
    logic [15:0] hold_reg;
    logic [15:0] hold_next;
    logic        last_reg;
    logic        last_next;

    logic        slot_free;
    logic        emit;
    logic        cur_last;
    logic [3:0]  cur_nibble;

    assign slot_free  = !out_valid_reg || wr_ready;
    assign emit       = active_reg && slot_free;
    assign cur_last   = !clear_pending_reg && (phase_reg == PH_EN_LOW)
                        && (nib_idx_reg == (is_init_reg ? INIT_LAST_NIB : BYTE_LAST_NIB));
    assign pop        = !q_stat.empty && (!active_reg || (emit && cur_last));
    assign cur_nibble = is_init_reg ? init_nibble(nib_idx_reg)
                        : (nib_idx_reg[0] ? cmd_byte_reg[3:0] : cmd_byte_reg[7:4]);

    assign wr_valid        = out_valid_reg;
    assign port_data       = port_data_reg;
    assign enable          = enable_reg;
    assign register_select = rs_out_reg;
    assign hold_ticks      = hold_reg;
    assign last            = last_reg;

    always_comb
    begin
        active_next        = active_reg;
        is_init_next       = is_init_reg;
        clear_pending_next = clear_pending_reg;
        cmd_byte_next      = cmd_byte_reg;
        rs_next            = rs_reg;
        nib_idx_next       = nib_idx_reg;
        phase_next         = phase_reg;

        if (emit)
        begin
            if (clear_pending_reg)
            begin
                clear_pending_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_DATA:    phase_next = PH_EN_HIGH;
                    PH_EN_HIGH: phase_next = PH_EN_LOW;
                    PH_EN_LOW:
                    begin
                        phase_next   = PH_DATA;
                        nib_idx_next = nib_idx_reg + 4'd1;
                    end
                    default:    phase_next = PH_DATA;
                endcase
            end
            if (cur_last)
            begin
                active_next = 1'b0;
            end
        end

        if (pop)
        begin
            active_next        = 1'b1;
            is_init_next       = pop_job.is_init;
            clear_pending_next = pop_job.is_init;
            cmd_byte_next      = pop_job.cmd_byte;
            rs_next            = pop_job.rs;
            nib_idx_next       = 4'd0;
            phase_next         = PH_DATA;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        port_data_next = port_data_reg;
        enable_next    = enable_reg;
        rs_out_next    = rs_out_reg;
        hold_next      = hold_reg;
        last_next      = last_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            if (clear_pending_reg)
            begin
                port_data_next = 4'h0;
                enable_next    = 1'b0;
                rs_out_next    = 1'b0;
                hold_next      = delay_cfg.long_delay;
                last_next      = 1'b0;
            end
            else
            begin
                port_data_next = cur_nibble;
                enable_next    = (phase_reg == PH_EN_HIGH);
                rs_out_next    = rs_reg;
                hold_next      = (phase_reg == PH_EN_LOW) ? delay_cfg.long_delay
                                 : delay_cfg.short_delay;
                last_next      = cur_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            clear_pending_reg <= 1'b0;
            phase_reg         <= PH_DATA;
            nib_idx_reg       <= 4'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            active_reg        <= active_next;
            clear_pending_reg <= clear_pending_next;
            phase_reg         <= phase_next;
            nib_idx_reg       <= nib_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_init_reg   <= is_init_next;
        cmd_byte_reg  <= cmd_byte_next;
        rs_reg        <= rs_next;
        port_data_reg <= port_data_next;
        enable_reg    <= enable_next;
        rs_out_reg    <= rs_out_next;
        hold_reg      <= hold_next;
        last_reg      <= last_next;
    end

`ifndef SYNTHESIS
    a_clear_only_at_init_start: assert property (@(posedge clk) disable iff (!rst_n)
        clear_pending_reg |-> active_reg && is_init_reg && nib_idx_reg == 4'd0
                              && phase_reg == PH_DATA)
        else $error("clear write pending outside the start of a power-up job");

    a_byte_job_two_nibbles: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !is_init_reg |-> nib_idx_reg <= BYTE_LAST_NIB)
        else $error("byte job ran past its second nibble");

    a_next_job_unstarted: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_ready && last |->
            !active_reg || (nib_idx_reg == 4'd0 && phase_reg == PH_DATA))
        else $error("next job advanced before the final write was taken");
`endif

endmodule

@@ rtl/lcd_nibble_interface_sequencer.sv @@
// lcd_nibble_interface_sequencer: top level, delay registers on the apb port,
// request front end, job queue and nibble sequencer; depends on lcdnib_pkg
//
// Each request (power-up, command byte, data byte, cursor move) becomes a
// series of port-write transfers for a display on a 4-bit bus. A byte goes
// out as six writes and power-up as 37, one per clock while the write side
// takes them, as the nibble sequencer produces them. The first write of a
// request passes the front job register, the job queue, the sequencer state
// and the sequencer output register when the sequencer is idle; behind a
// busy sequencer it follows the last write of the request before it
// with no gap. hold_ticks is only reported with each write; the block
// itself does not wait. short_delay sits at address 0x0, long_delay at 0x4.
module lcd_nibble_interface_sequencer
    import lcdnib_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [1:0]            mode,
    input  logic [7:0]            value,
    input  logic                  row,
    input  logic [3:0]            column,
    output logic                  wr_valid,
    input  logic                  wr_ready,
    output logic [3:0]            port_data,
    output logic                  enable,
    output logic                  register_select,
    output logic [15:0]           hold_ticks,
    output logic                  last
);

    logic [15:0] short_delay_reg;
    logic [15:0] short_delay_next;
    logic [15:0] long_delay_reg;
    logic [15:0] long_delay_next;
    logic        cfg_write;
    logic        reg_sel;
    delay_cfg_t  delay_cfg;
    q_stat_t     q_stat;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        pop_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[2];

    assign delay_cfg.short_delay = short_delay_reg;
    assign delay_cfg.long_delay  = long_delay_reg;

    always_comb
    begin
        short_delay_next = short_delay_reg;
        long_delay_next  = long_delay_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                REG_SHORT_DELAY: short_delay_next = pwdata[15:0];
                REG_LONG_DELAY:  long_delay_next  = pwdata[15:0];
                default:         short_delay_next = short_delay_reg;
            endcase
        end
        case (reg_sel)
            REG_SHORT_DELAY: prdata = {16'h0000, short_delay_reg};
            REG_LONG_DELAY:  prdata = {16'h0000, long_delay_reg};
            default:         prdata = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_delay_reg <= SHORT_DELAY_RST;
            long_delay_reg  <= LONG_DELAY_RST;
        end
        else
        begin
            short_delay_reg <= short_delay_next;
            long_delay_reg  <= long_delay_next;
        end
    end

    lcdnib_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .mode      (mode),
        .value     (value),
        .row       (row),
        .column    (column),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    lcdnib_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    lcdnib_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .delay_cfg       (delay_cfg),
        .q_stat          (q_stat),
        .pop_job         (pop_job),
        .pop             (pop),
        .wr_valid        (wr_valid),
        .wr_ready        (wr_ready),
        .port_data       (port_data),
        .enable          (enable),
        .register_select (register_select),
        .hold_ticks      (hold_ticks),
        .last            (last)
    );

endmodule

@@ dv/tb.sv @@
// tb: self-checking testbench for lcd_nibble_interface_sequencer, predicts every
// port write of each request and compares it with the write side of the dut
// depends on lcdnib_pkg and the dut rtl
module tb;
    import lcdnib_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] ADDR_SHORT_DELAY = 3'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_LONG_DELAY  = 3'h4;

    localparam logic [3:0] WAKE_NIB      = 4'h3;
    localparam logic [3:0] BUS_4BIT_NIB  = 4'h2;
    localparam logic [7:0] FUNCTION_SET  = 8'h28;
    localparam logic [7:0] DISPLAY_ON    = 8'h0C;
    localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
    localparam logic [7:0] ENTRY_MODE    = 8'h06;
    localparam logic       RS_COMMAND    = 1'b0;
    localparam logic       RS_DATA       = 1'b1;

    typedef struct packed {
        logic [3:0]  data;
        logic        en;
        logic        rs;
        logic [15:0] hold;
        logic        last;
    } port_write_t;

    typedef struct {
        mode_t      mode;
        logic [7:0] value;
        logic       row;
        logic [3:0] column;
    } lcd_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    mode_t       mode = MODE_INIT;
    logic [7:0]  value = '0;
    logic        row = 1'b0;
    logic [3:0]  column = '0;
    logic        wr_valid;
    logic        wr_ready = 1'b0;
    logic [3:0]  port_data;
    logic        enable;
    logic        register_select;
    logic [15:0] hold_ticks;
    logic        last;

    lcd_request_t pending_requests[$];
    port_write_t  expected_writes[$];
    logic [15:0]  short_delay_cfg = SHORT_DELAY_RST;
    logic [15:0]  long_delay_cfg  = LONG_DELAY_RST;
    int           mismatches = 0;
    int           send_gap = 0;
    int           stall_left = 0;
    bit           no_idle = 1'b0;

    lcd_nibble_interface_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .mode            (mode),
        .value           (value),
        .row             (row),
        .column          (column),
        .wr_valid        (wr_valid),
        .wr_ready        (wr_ready),
        .port_data       (port_data),
        .enable          (enable),
        .register_select (register_select),
        .hold_ticks      (hold_ticks),
        .last            (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 70)
            return 0;
        else if (r < 96)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic void push_write(logic [3:0] data, logic en, logic rs, logic [15:0] hold);
        port_write_t w;
        w.data = data;
        w.en   = en;
        w.rs   = rs;
        w.hold = hold;
        w.last = 1'b0;
        expected_writes.push_back(w);
    endfunction

    function automatic void push_nibble(logic [3:0] nib, logic rs);
        push_write(nib, 1'b0, rs, short_delay_cfg);
        push_write(nib, 1'b1, rs, short_delay_cfg);
        push_write(nib, 1'b0, rs, long_delay_cfg);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic rs);
        push_nibble(b[7:4], rs);
        push_nibble(b[3:0], rs);
    endfunction

    function automatic void predict_port_writes(mode_t m, logic [7:0] v, logic r, logic [3:0] c);
        port_write_t final_write;
        case (m)
            MODE_INIT:
            begin
                push_write(4'h0, 1'b0, RS_COMMAND, long_delay_cfg);
                push_nibble(WAKE_NIB, RS_COMMAND);
                push_nibble(WAKE_NIB, RS_COMMAND);
                push_nibble(WAKE_NIB, RS_COMMAND);
                push_nibble(BUS_4BIT_NIB, RS_COMMAND);
                push_byte(FUNCTION_SET, RS_COMMAND);
                push_byte(DISPLAY_ON, RS_COMMAND);
                push_byte(CLEAR_DISPLAY, RS_COMMAND);
                push_byte(ENTRY_MODE, RS_COMMAND);
            end
            MODE_CMD:  push_byte(v, RS_COMMAND);
            MODE_DATA: push_byte(v, RS_DATA);
            default:   push_byte(CURSOR_BASE + (r ? ROW_OFFSET : 8'h00) + {4'h0, c}, RS_COMMAND);
        endcase
        final_write = expected_writes.pop_back();
        final_write.last = 1'b1;
        expected_writes.push_back(final_write);
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        lcd_request_t req;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            send_gap  <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                predict_port_writes(mode, value, row, column);
            if (!cmd_valid || cmd_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap  <= send_gap - 1;
                    cmd_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    req = pending_requests.pop_front();
                    cmd_valid <= 1'b1;
                    mode      <= req.mode;
                    value     <= req.value;
                    row       <= req.row;
                    column    <= req.column;
                    send_gap  <= pick_gap();
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // port write monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : write_monitor
        port_write_t exp_w;
        int g;
        if (!rst_n)
        begin
            wr_ready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (wr_valid && wr_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $display("%0t: unexpected port write, actual data %0h en %0b rs %0b hold %0h last %0b",
                             $realtime, port_data, enable, register_select, hold_ticks, last);
                    mismatches++;
                end
                else
                begin
                    exp_w = expected_writes.pop_front();
                    check_field("port_data", 16'(exp_w.data), 16'(port_data));
                    check_field("enable", 16'(exp_w.en), 16'(enable));
                    check_field("register_select", 16'(exp_w.rs), 16'(register_select));
                    check_field("hold_ticks", exp_w.hold, hold_ticks);
                    check_field("last", 16'(exp_w.last), 16'(last));
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                wr_ready   <= (stall_left == 1);
            end
            else
            begin
                g = pick_gap();
                stall_left <= g;
                wr_ready   <= (g == 0);
            end
        end
    end

    task automatic reg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SHORT_DELAY)
            short_delay_cfg = data[15:0];
        else if (addr == ADDR_LONG_DELAY)
            long_delay_cfg = data[15:0];
    endtask

    task automatic add_request(mode_t m, logic [7:0] v, logic r, logic [3:0] c);
        lcd_request_t req;
        req.mode   = m;
        req.value  = v;
        req.row    = r;
        req.column = c;
        pending_requests.push_back(req);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || cmd_valid || expected_writes.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        add_request(MODE_INIT, 8'h00, 1'b0, 4'h0);
        add_request(MODE_CMD, 8'h00, 1'b0, 4'h0);
        add_request(MODE_CMD, 8'hFF, 1'b1, 4'hF);
        add_request(MODE_DATA, 8'h00, 1'b1, 4'hF);
        add_request(MODE_DATA, 8'hFF, 1'b0, 4'h0);
        add_request(MODE_DATA, 8'hA5, 1'b0, 4'h5);
        add_request(MODE_CMD, 8'h5A, 1'b1, 4'hA);
        add_request(MODE_CURSOR, 8'hFF, 1'b0, 4'h0);
        add_request(MODE_CURSOR, 8'h00, 1'b0, 4'hF);
        add_request(MODE_CURSOR, 8'hFF, 1'b1, 4'h0);
        add_request(MODE_CURSOR, 8'h00, 1'b1, 4'hF);
        add_request(MODE_INIT, 8'hFF, 1'b1, 4'hF);
        add_request(MODE_DATA, 8'h80, 1'b1, 4'h3);
        add_request(MODE_CMD, 8'h01, 1'b0, 4'hC);
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            no_idle = (ph == 2);
            case (ph)
                0:
                begin
                    reg_write(ADDR_SHORT_DELAY, 32'h0000_0000);
                    reg_write(ADDR_LONG_DELAY, 32'h0000_0000);
                end
                1:
                begin
                    reg_write(ADDR_SHORT_DELAY, 32'h0000_FFFF);
                    reg_write(ADDR_LONG_DELAY, 32'hFFFF_FFFF);
                end
                2:
                begin
                    reg_write(ADDR_SHORT_DELAY, $urandom);
                    reg_write(ADDR_LONG_DELAY, $urandom);
                end
                3:
                begin
                    reg_write(ADDR_SHORT_DELAY, 32'hFFFF_0000);
                    reg_write(ADDR_LONG_DELAY, 32'h0000_FFFF);
                end
                default:
                begin
                    reg_write(ADDR_LONG_DELAY, $urandom);
                    reg_write(ADDR_SHORT_DELAY, 32'h0000_0001);
                end
            endcase
            for (int i = 0; i < 52; i++)
            begin
                r = $urandom_range(99);
                if (r < 10)
                    add_request(MODE_INIT, 8'($urandom), 1'($urandom), 4'($urandom));
                else if (r < 40)
                    add_request(MODE_CMD, 8'($urandom), 1'($urandom), 4'($urandom));
                else if (r < 70)
                    add_request(MODE_DATA, 8'($urandom), 1'($urandom), 4'($urandom));
                else
                    add_request(MODE_CURSOR, 8'($urandom), 1'($urandom), 4'($urandom));
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
